/* hw/rtl/s2c_pkg.sv */
package s2c_pkg;

    localparam int unsigned SecsPerDay  = 86400;
    localparam int unsigned SecsPerHour = 3600;
    localparam int unsigned SecsPerMin  = 60;
    localparam int unsigned FirstYear   = 2000;
    localparam int unsigned DaysLeap    = 366;
    localparam int unsigned DaysCommon  = 365;

    // The 2000..2136 range has exactly one century that is not a leap year.
    localparam int unsigned NonLeapCentury = 2100;

    // Quotient widths of the three shift-subtract divisions.
    localparam int unsigned DayQuotBits  = 16;
    localparam int unsigned HourQuotBits = 5;
    localparam int unsigned MinQuotBits  = 6;

    localparam int unsigned LastMonth = 11;

    typedef logic [2:0] phase_t;

    localparam phase_t ST_IDLE   = 3'd0;
    localparam phase_t ST_DAYS   = 3'd1;
    localparam phase_t ST_HOURS  = 3'd2;
    localparam phase_t ST_MINS   = 3'd3;
    localparam phase_t ST_YEARS  = 3'd4;
    localparam phase_t ST_MONTHS = 3'd5;
    localparam phase_t ST_DONE   = 3'd6;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] shift;
        logic       leap;
        logic [3:0] month;
    } step_ctrl_t;

    typedef struct packed {
        logic [31:0] diff;
        logic        ge;
    } step_res_t;

    function automatic logic [4:0] month_days(input logic leap, input logic [3:0] month);
        logic [3:0] m;
        begin
            m = (month > 4'd6) ? (month - 4'd1) : month;
            if (month == 4'd1)
            begin
                month_days = leap ? 5'd29 : 5'd28;
            end
            else
            begin
                month_days = m[0] ? 5'd30 : 5'd31;
            end
        end
    endfunction

endpackage

/* hw/rtl/s2c_step.sv */
module s2c_step (
    input  s2c_pkg::step_ctrl_t ctrl,
    input  logic [31:0]         rem,
    output s2c_pkg::step_res_t  res
);

    logic [31:0] operand;
    logic [32:0] diff_ext;

    // Each phase picks what the single subtractor takes away from the remainder.
    always_comb
    begin
        case (ctrl.phase)
            s2c_pkg::ST_DAYS:
            begin
                operand = 32'(s2c_pkg::SecsPerDay) << ctrl.shift;
            end
            s2c_pkg::ST_HOURS:
            begin
                operand = 32'(s2c_pkg::SecsPerHour) << ctrl.shift;
            end
            s2c_pkg::ST_MINS:
            begin
                operand = 32'(s2c_pkg::SecsPerMin) << ctrl.shift;
            end
            s2c_pkg::ST_YEARS:
            begin
                operand = ctrl.leap ? 32'(s2c_pkg::DaysLeap) : 32'(s2c_pkg::DaysCommon);
            end
            s2c_pkg::ST_MONTHS:
            begin
                operand = {27'b0, s2c_pkg::month_days(ctrl.leap, ctrl.month)};
            end
            default:
            begin
                operand = 32'b0;
            end
        endcase
    end

    assign diff_ext = {1'b0, rem} - {1'b0, operand};
    assign res.diff = diff_ext[31:0];
    assign res.ge   = ~diff_ext[32];

endmodule

/* hw/rtl/seconds_to_calendar.sv */
// Channel   Dir  Fields (tdata, lowest bit first)
// s_axis    in   epoch_seconds[31:0]
// m_axis    out  year[11:0] month_index[15:12] day_index[20:16] hour[25:21]
//                minute[31:26] second[37:32], zero fill [39:38]
//
// One request takes 16 + 5 + 6 division steps, one step per elapsed year plus one,
// and one step per elapsed month plus one, all on a single shared subtractor.
// The input is ready only while the sequencer is idle; the result is held until taken.
// An asynchronous active-low reset returns the sequencer to idle.
module seconds_to_calendar (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // epoch_seconds
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // year, month_index, day_index, hour, minute, second
);

    localparam logic [7:0] LeapSkipOff = 8'(s2c_pkg::NonLeapCentury - s2c_pkg::FirstYear);

    s2c_pkg::phase_t state_reg, state_next;
    logic [3:0]      shift_reg, shift_next;
    logic [31:0]     rem_reg, rem_next;
    logic [15:0]     quot_reg, quot_next;
    logic [15:0]     days_reg, days_next;
    logic [7:0]      year_off_reg, year_off_next;
    logic [3:0]      month_reg, month_next;
    logic [4:0]      hour_reg, hour_next;
    logic [5:0]      minute_reg, minute_next;
    logic [5:0]      second_reg, second_next;

    s2c_pkg::step_ctrl_t ctrl;
    s2c_pkg::step_res_t  res;
    logic                leap;
    logic [15:0]         quot_shift;
    logic [31:0]         rem_sel;
    logic [11:0]         year_full;

    // Within 2000..2136 a year is a leap year when divisible by 4, except 2100.
    assign leap = (year_off_reg[1:0] == 2'b00) && (year_off_reg != LeapSkipOff);

    assign ctrl.phase = state_reg;
    assign ctrl.shift = shift_reg;
    assign ctrl.leap  = leap;
    assign ctrl.month = month_reg;

    s2c_step u_step (
        .ctrl (ctrl),
        .rem  (rem_reg),
        .res  (res)
    );

    assign quot_shift = {quot_reg[14:0], res.ge};
    assign rem_sel    = res.ge ? res.diff : rem_reg;

    always_comb
    begin
        state_next    = state_reg;
        shift_next    = shift_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        days_next     = days_reg;
        year_off_next = year_off_reg;
        month_next    = month_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        second_next   = second_reg;
        case (state_reg)
            s2c_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    rem_next   = s_axis_tdata;
                    quot_next  = 16'b0;
                    shift_next = 4'(s2c_pkg::DayQuotBits - 1);
                    state_next = s2c_pkg::ST_DAYS;
                end
            end
            s2c_pkg::ST_DAYS:
            begin
                rem_next  = rem_sel;
                quot_next = quot_shift;
                if (shift_reg == 4'd0)
                begin
                    days_next  = quot_shift;
                    quot_next  = 16'b0;
                    shift_next = 4'(s2c_pkg::HourQuotBits - 1);
                    state_next = s2c_pkg::ST_HOURS;
                end
                else
                begin
                    shift_next = shift_reg - 4'd1;
                end
            end
            s2c_pkg::ST_HOURS:
            begin
                rem_next  = rem_sel;
                quot_next = quot_shift;
                if (shift_reg == 4'd0)
                begin
                    hour_next  = quot_shift[4:0];
                    quot_next  = 16'b0;
                    shift_next = 4'(s2c_pkg::MinQuotBits - 1);
                    state_next = s2c_pkg::ST_MINS;
                end
                else
                begin
                    shift_next = shift_reg - 4'd1;
                end
            end
            s2c_pkg::ST_MINS:
            begin
                rem_next  = rem_sel;
                quot_next = quot_shift;
                if (shift_reg == 4'd0)
                begin
                    minute_next   = quot_shift[5:0];
                    second_next   = rem_sel[5:0];
                    rem_next      = {16'b0, days_reg};
                    year_off_next = 8'd0;
                    state_next    = s2c_pkg::ST_YEARS;
                end
                else
                begin
                    shift_next = shift_reg - 4'd1;
                end
            end
            s2c_pkg::ST_YEARS:
            begin
                if (res.ge)
                begin
                    rem_next      = res.diff;
                    year_off_next = year_off_reg + 8'd1;
                end
                else
                begin
                    month_next = 4'd0;
                    state_next = s2c_pkg::ST_MONTHS;
                end
            end
            s2c_pkg::ST_MONTHS:
            begin
                if ((month_reg != 4'(s2c_pkg::LastMonth)) && res.ge)
                begin
                    rem_next   = res.diff;
                    month_next = month_reg + 4'd1;
                end
                else
                begin
                    state_next = s2c_pkg::ST_DONE;
                end
            end
            s2c_pkg::ST_DONE:
            begin
                if (m_axis_tready)
                begin
                    state_next = s2c_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = s2c_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= s2c_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg    <= shift_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        days_reg     <= days_next;
        year_off_reg <= year_off_next;
        month_reg    <= month_next;
        hour_reg     <= hour_next;
        minute_reg   <= minute_next;
        second_reg   <= second_next;
    end

    assign year_full     = 12'(s2c_pkg::FirstYear) + {4'b0, year_off_reg};
    assign s_axis_tready = (state_reg == s2c_pkg::ST_IDLE);
    assign m_axis_tvalid = (state_reg == s2c_pkg::ST_DONE);
    assign m_axis_tdata  = {2'b00, second_reg, minute_reg, hour_reg, rem_reg[4:0],
                            month_reg, year_full};

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    a_start_days: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=>
        (state_reg == s2c_pkg::ST_DAYS) && (shift_reg == 4'(s2c_pkg::DayQuotBits - 1)))
        else $error("accepted request did not start the day division");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (hour_reg < 5'd24) && (minute_reg < 6'd60) && (second_reg < 6'd60))
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (month_reg <= 4'(s2c_pkg::LastMonth)) && (rem_reg < 32'd31))
        else $error("month or day of month out of range");

endmodule
